### src/sha256_message_hasher_assert.svh
// assertion macros for the sha256 message hasher
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

`ifndef SYNTHESIS

`define SHA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define SHA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SHA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)

`define SHA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

### src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

   typedef struct packed {
      logic       load_byte;
      logic       pad;
      logic       pad_mark;
      logic       pad_len;
      logic       init_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       fold;
      logic       reinit;
      logic [2:0] word_sel;
   } sha256_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_high;
   } sha256_status_type;

   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [5:0] LAST_BYTE  = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [2:0] LAST_WORD  = 3'd7;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

### src/sha256_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### src/sha256_message_hasher.sv
// sha-256 hasher for byte streams
// req_chan carries one item per message byte (command 0) or a finish item
// (command 1, data_byte ignored). rsp_chan returns the eight digest words of
// a finished message, word_index 0 first, last_word set on word 7.
// a byte that does not complete a 64-byte block leaves the hasher idle. the
// byte that completes one holds the input off while the block is hashed:
// load, 64 rounds of the single round unit, a fold into the chaining value.
// a finish item hashes the padded last block before the first word is
// offered, plus a second, length-only block when 56 or more bytes of the
// last block are held. the words go out one per cycle while rsp_chan.ready
// is high; a stalled receiver holds the current word and the block waits.
// the next message can start right after the eighth word is taken.
// input and output never overlap: req_chan.ready is high only while idle.
// reset is synchronous: the chaining value returns to the initial hash words,
// the byte count and bit length to zero, and any item in progress is dropped.
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_message_hasher_assert.svh"

module sha256_message_hasher (
   input wire logic     clock,
   input wire logic     reset,
   sha256_req_if.sink   req_chan,
   sha256_rsp_if.source rsp_chan
);

   sha256_pkg::sha256_cmd_type    cmd;
   sha256_pkg::sha256_status_type status;
   logic                          req_fire;
   logic                          rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   sha256_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_command (req_chan.command),
      .rsp_fire    (rsp_fire),
      .status      (status),
      .cmd         (cmd),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .word_index  (rsp_chan.word_index),
      .last_word   (rsp_chan.last_word)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_chan.data_byte),
      .status      (status),
      .digest_word (rsp_chan.digest_word)
   );

   `SHA_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_chan.valid, !req_chan.ready, "rsp valid while taking input")
   `SHA_ASSERT_NEXT(a_finish_busy, clock, reset, req_fire && req_chan.command, !req_chan.ready && !rsp_chan.valid, "finish item not followed by compression")
   `SHA_ASSERT_NEXT(a_done_idle, clock, reset, rsp_fire && rsp_chan.last_word, req_chan.ready && !rsp_chan.valid, "not idle after last word")
   `SHA_ASSERT_NEXT(a_word_step, clock, reset, rsp_fire && !rsp_chan.last_word, rsp_chan.valid && (rsp_chan.word_index == $past(rsp_chan.word_index) + 3'd1), "digest words out of order")

endmodule

`default_nettype wire

### src/sha256_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sha256_pkg::sha256_cmd_type    cmd,
   input  wire logic [7:0]                    data_byte,
   output      sha256_pkg::sha256_status_type status,
   output      logic [31:0]                   digest_word
);

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] window_ff [16];
   logic [31:0] window_in [16];
   logic [31:0] sched_word;
   logic [31:0] t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // message schedule, window holds w[t] .. w[t+15]
   assign sched_word = (rotr(window_ff[14], 17) ^ rotr(window_ff[14], 19) ^
                        (window_ff[14] >> 10)) + window_ff[9] +
                       (rotr(window_ff[1], 7) ^ rotr(window_ff[1], 18) ^
                        (window_ff[1] >> 3)) + window_ff[0];

   assign t1 = vars_ff[7] +
               (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25)) +
               ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6])) +
               sha256_pkg::ROUND_K[cmd.round_idx] + window_ff[0];

   assign t2 = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22)) +
               ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^
                (vars_ff[1] & vars_ff[2]));

   always_comb begin
      window_in = window_ff;
      if (cmd.round_en) begin
         for (int j = 0; j < 15; j++) begin
            window_in[j] = window_ff[j + 1];
         end
         window_in[15] = sched_word;
      end else begin
         for (int j = 0; j < 16; j++) begin
            for (int b = 0; b < 4; b++) begin
               priority if (cmd.pad) begin
                  if (cmd.pad_mark && (6'(4 * j + b) < fill_ff)) begin
                     window_in[j][8 * (3 - b) +: 8] = window_ff[j][8 * (3 - b) +: 8];
                  end else if (cmd.pad_mark && (6'(4 * j + b) == fill_ff)) begin
                     window_in[j][8 * (3 - b) +: 8] = sha256_pkg::PAD_MARK;
                  end else begin
                     window_in[j][8 * (3 - b) +: 8] = 8'h00;
                  end
               end else if (cmd.load_byte && (6'(4 * j + b) == fill_ff)) begin
                  window_in[j][8 * (3 - b) +: 8] = data_byte;
               end else begin
                  window_in[j][8 * (3 - b) +: 8] = window_ff[j][8 * (3 - b) +: 8];
               end
            end
         end
         if (cmd.pad && cmd.pad_len) begin
            window_in[14] = bits_ff[63:32];
            window_in[15] = bits_ff[31:0];
         end
      end
   end

   always_comb begin
      vars_in = vars_ff;
      priority if (cmd.init_vars) begin
         vars_in = chain_ff;
      end else if (cmd.round_en) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end else begin
         vars_in = vars_ff;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      priority if (cmd.reinit) begin
         chain_in = sha256_pkg::INIT_HASH;
         fill_in  = 6'd0;
         bits_in  = 64'd0;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end else if (cmd.load_byte) begin
         fill_in = fill_ff + 6'd1;
         bits_in = bits_ff + 64'd8;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha256_pkg::INIT_HASH;
         fill_ff  <= 6'd0;
         bits_ff  <= 64'd0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      vars_ff   <= vars_in;
   end

   assign status.fill_last = (fill_ff == sha256_pkg::LAST_BYTE);
   assign status.fill_high = (fill_ff >= sha256_pkg::LEN_START);
   assign digest_word      = chain_ff[cmd.word_sel];

endmodule

`default_nettype wire

### src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_fire,
   input  wire logic                          req_command,
   input  wire logic                          rsp_fire,
   input  wire sha256_pkg::sha256_status_type status,
   output      sha256_pkg::sha256_cmd_type    cmd,
   output      logic                          req_ready,
   output      logic                          rsp_valid,
   output      logic [2:0]                    word_index,
   output      logic                          last_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       final_ff, final_in;
   logic       second_ff, second_in;

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      word_in   = word_ff;
      final_in  = final_ff;
      second_in = second_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (!req_command) begin
                  cmd.load_byte = 1'b1;
                  final_in      = 1'b0;
                  second_in     = 1'b0;
                  if (status.fill_last) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  // first padded block, length goes in only if it fits
                  cmd.pad      = 1'b1;
                  cmd.pad_mark = 1'b1;
                  cmd.pad_len  = !status.fill_high;
                  final_in     = 1'b1;
                  second_in    = status.fill_high;
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.init_vars = 1'b1;
            round_in      = 6'd0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en  = 1'b1;
            cmd.round_idx = round_ff;
            round_in      = round_ff + 6'd1;
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (second_ff) begin
               // length-only block
               cmd.pad     = 1'b1;
               cmd.pad_len = 1'b1;
               second_in   = 1'b0;
               state_in    = ST_LOAD;
            end else if (final_ff) begin
               word_in  = 3'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid    = 1'b1;
            cmd.word_sel = word_ff;
            if (rsp_fire) begin
               word_in = word_ff + 3'd1;
               if (word_ff == sha256_pkg::LAST_WORD) begin
                  cmd.reinit = 1'b1;
                  final_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= 6'd0;
         word_ff   <= 3'd0;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
         final_ff  <= final_in;
         second_ff <= second_in;
      end
   end

   assign word_index = word_ff;
   assign last_word  = (word_ff == sha256_pkg::LAST_WORD);

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam bit CMD_ABSORB = 1'b0;
   localparam bit CMD_FINISH = 1'b1;
   localparam int IDLE_PERCENT = 15;
   localparam int TOTAL_ITEMS = 220;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   class digest_scoreboard;
      bit [31:0] chain [8];
      bit [7:0] block [64];
      int unsigned fill;
      bit [63:0] bit_count;
      digest_entry_type digest_words [$];
      int errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = sha256_pkg::INIT_HASH[i];
         fill = 0;
         bit_count = '0;
      endfunction

      function bit [31:0] rotr(bit [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         bit [31:0] w [64];
         bit [31:0] v [8];
         bit [31:0] s0, s1, t1, t2;
         for (int t = 0; t < 16; t++)
            w[t] = {block[4 * t], block[4 * t + 1], block[4 * t + 2], block[4 * t + 3]};
         for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t - 15], 7) ^ rotr(w[t - 15], 18) ^ (w[t - 15] >> 3);
            s1 = rotr(w[t - 2], 17) ^ rotr(w[t - 2], 19) ^ (w[t - 2] >> 10);
            w[t] = s1 + w[t - 7] + s0 + w[t - 16];
         end
         foreach (v[i]) v[i] = chain[i];
         for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         foreach (chain[i]) chain[i] += v[i];
      endfunction

      function void note_item(bit cmd, bit [7:0] data);
         int unsigned pos;
         digest_entry_type entry;
         if (cmd == CMD_ABSORB) begin
            block[fill] = data;
            bit_count += 64'd8;
            fill++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
            return;
         end
         pos = fill;
         block[pos] = sha256_pkg::PAD_MARK;
         pos++;
         // no room left for the length, so pad out a separate block
         if (pos > sha256_pkg::LEN_START) begin
            while (pos < 64) begin
               block[pos] = 8'h00;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < sha256_pkg::LEN_START) begin
            block[pos] = 8'h00;
            pos++;
         end
         for (int k = 0; k < 8; k++)
            block[sha256_pkg::LEN_START + k] = 8'(bit_count >> (56 - 8 * k));
         compress();
         for (int k = 0; k < 8; k++) begin
            entry.word = chain[k];
            entry.index = 3'(k);
            entry.last = (3'(k) == sha256_pkg::LAST_WORD);
            digest_words.push_back(entry);
         end
         restart();
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_entry_type exp_entry;
         if (digest_words.size() == 0) begin
            $error("unexpected item: digest_word %h word_index %0d", word, index);
            errors++;
            return;
         end
         exp_entry = digest_words.pop_front();
         if (word !== exp_entry.word) begin
            $error("digest_word expected %h actual %h", exp_entry.word, word);
            errors++;
         end
         if (index !== exp_entry.index) begin
            $error("word_index expected %0d actual %0d", exp_entry.index, index);
            errors++;
         end
         if (last !== exp_entry.last) begin
            $error("last_word expected %0d actual %0d", exp_entry.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit steady = 1'b0;
   int sent_items = 0;
   int stall_count = 0;
   digest_scoreboard sb = new();

   sha256_req_if req_if ();
   sha256_rsp_if rsp_if ();

   sha256_message_hasher uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word(rsp_if.digest_word, rsp_if.word_index, rsp_if.last_word);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_item(bit cmd, bit [7:0] data);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.command = cmd;
      req_if.data_byte = data;
      do @(posedge clock); while (!req_if.ready);
      sb.note_item(cmd, data);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.digest_words.size() != 0) @(negedge clock);
   endtask

   task automatic send_message(int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         send_item(CMD_ABSORB, 8'($urandom_range(255)));
      send_item(CMD_FINISH, 8'($urandom_range(255)));
   endtask

   initial begin
      int msg_count;
      int unsigned length;
      req_if.valid = 1'b0;
      req_if.command = CMD_ABSORB;
      req_if.data_byte = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty message, then single extreme bytes and the three-byte message abc
      send_item(CMD_FINISH, 8'hff);
      wait_drained();
      send_item(CMD_ABSORB, 8'h00);
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_ABSORB, 8'hff);
      send_item(CMD_FINISH, 8'hff);
      send_item(CMD_ABSORB, 8'h61);
      send_item(CMD_ABSORB, 8'h62);
      send_item(CMD_ABSORB, 8'h63);
      send_item(CMD_FINISH, 8'h00);
      // back-to-back finishes
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_FINISH, 8'h5a);

      msg_count = 0;
      while (sent_items < TOTAL_ITEMS) begin
         case (msg_count)
            0, 2: length = $urandom_range(63, 56);
            1: length = $urandom_range(70, 64);
            default: begin
               if ($urandom_range(3) == 0)
                  length = $urandom_range(70);
               else
                  length = $urandom_range(24);
            end
         endcase
         if (sent_items + int'(length) >= TOTAL_ITEMS)
            length = unsigned'(TOTAL_ITEMS - sent_items - 1);
         steady = (msg_count == 1);
         if ($urandom_range(3) == 0)
            wait_drained();
         send_message(length);
         msg_count++;
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.digest_words.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
